FILE: rtl/keyed_neighbor_table_defines.svh
// assertion macros used by the keyed neighbor table controller
`ifndef KEYED_NEIGHBOR_TABLE_DEFINES_SVH
`define KEYED_NEIGHBOR_TABLE_DEFINES_SVH

// plain property checked on every clock outside reset
`define KNT_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("keyed_neighbor_table: assertion failed");

// condition in one cycle implies expression in the next
`define KNT_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("keyed_neighbor_table: sequence assertion failed");

`endif

FILE: rtl/knt_pkg.sv
// types, codes and sizes shared by the keyed neighbor table
`timescale 1ns / 1ps

package knt_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int ACTION_W = 3;
    localparam int KEY_W    = 64;
    localparam int HOST_W   = 64;
    localparam int CAPS_W   = 32;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 32;
    localparam int SLOT_W   = 5;
    localparam int LIVE_W   = 6;

    localparam logic [ACTION_W-1:0] ACT_ADD  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SEEN = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DROP = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FIND = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic [HOST_W-1:0]   host_word;
        logic [CAPS_W-1:0]   caps;
        logic [INDEX_W-1:0]  index;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     peer_id;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    entry_key;
        logic [HOST_W-1:0]   entry_host;
        logic [CAPS_W-1:0]   entry_caps;
        logic [LIVE_W-1:0]   live_count;
    } t_result;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HOST_W-1:0] host;
        logic [CAPS_W-1:0] caps;
        logic [ID_W-1:0]   id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: rtl/knt_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module knt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/knt_ctrl.sv
// sequencer that scans the peer table one slot per cycle through a shared key compare
`timescale 1ns / 1ps
`include "keyed_neighbor_table_defines.svh"

module knt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  knt_pkg::t_item  i_item,
    input  logic            i_out_free,
    output logic            o_ready,
    output logic            o_done,
    output knt_pkg::t_result o_result
);

    import knt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_MISS = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        r_state, n_state;
    t_item             r_item, n_item;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ID_W-1:0]   r_next_id, n_next_id;
    t_result           r_res, n_res;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    t_entry            w_wdata;
    t_entry            w_rd;
    logic [ENTRY_W-1:0] w_rd_bits;
    logic [ADDR_W-1:0] w_last;
    logic              w_match;

    knt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_bits)
    );

    assign w_rd    = t_entry'(w_rd_bits);
    assign w_last  = ADDR_W'(r_count - CNT_W'(1));
    assign w_match = (w_rd.key == r_item.key);

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_count   = r_count;
        n_next_id = r_next_id;
        n_res     = r_res;
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_wdata   = w_rd;
        w_raddr   = r_idx;
        o_done    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item = i_item;
                    n_res  = '0;
                    n_res.live_count = LIVE_W'(r_count);
                    case (i_item.action)
                        ACT_ADD, ACT_SEEN, ACT_DROP, ACT_FIND: begin
                            w_raddr = '0;
                            n_idx   = '0;
                            n_state = (r_count == '0) ? S_MISS : S_SCAN;
                        end
                        ACT_READ: begin
                            n_res.slot = SLOT_W'(i_item.index);
                            if (CNT_W'(i_item.index) < r_count) begin
                                w_raddr = ADDR_W'(i_item.index);
                                n_state = S_READ;
                            end else begin
                                n_res.status = ST_RANGE;
                                n_state      = S_DONE;
                            end
                        end
                        default: begin
                            n_res.status = ST_RANGE;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    n_pos         = r_idx;
                    n_res.status  = ST_OK;
                    n_res.peer_id = w_rd.id;
                    n_state       = S_DONE;
                    case (r_item.action)
                        ACT_ADD: begin
                            w_we    = 1'b1;
                            w_waddr = r_idx;
                            w_wdata = '{key: r_item.key, host: r_item.host_word,
                                        caps: r_item.caps, id: w_rd.id};
                        end
                        ACT_FIND: begin
                            n_res.slot = SLOT_W'(r_idx);
                        end
                        ACT_DROP: begin
                            n_count          = r_count - CNT_W'(1);
                            n_res.live_count = LIVE_W'(r_count - CNT_W'(1));
                            if (r_idx != w_last) begin
                                w_raddr = w_last;
                                n_state = S_MOVE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (r_idx == w_last) begin
                    n_state = S_MISS;
                end else begin
                    w_raddr = r_idx + ADDR_W'(1);
                    n_idx   = r_idx + ADDR_W'(1);
                end
            end
            S_MOVE: begin
                // last entry fills the freed slot
                w_we    = 1'b1;
                w_waddr = r_pos;
                w_wdata = w_rd;
                n_state = S_DONE;
            end
            S_MISS: begin
                if (r_item.action == ACT_ADD) begin
                    if (r_count == CNT_W'(MAX_ENTRIES)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = ADDR_W'(r_count);
                        w_wdata = '{key: r_item.key, host: r_item.host_word,
                                    caps: r_item.caps, id: r_next_id};
                        n_res.status     = ST_OK;
                        n_res.peer_id    = r_next_id;
                        n_res.live_count = LIVE_W'(r_count + CNT_W'(1));
                        n_count          = r_count + CNT_W'(1);
                        n_next_id        = r_next_id + ID_W'(1);
                    end
                end else begin
                    n_res.status = ST_MISS;
                end
                n_state = S_DONE;
            end
            S_READ: begin
                n_res.status     = ST_OK;
                n_res.peer_id    = w_rd.id;
                n_res.entry_key  = w_rd.key;
                n_res.entry_host = w_rd.host;
                n_res.entry_caps = w_rd.caps;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_next_id <= ID_W'(1);
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_next_id <= n_next_id;
        end
        r_item <= n_item;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_res  <= n_res;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_result = r_res;

    `KNT_ASSERT(a_count_bound, r_count <= CNT_W'(MAX_ENTRIES))
    `KNT_ASSERT(a_write_state, !w_we || r_state == S_SCAN || r_state == S_MOVE
                               || r_state == S_MISS)
    `KNT_ASSERT(a_scan_in_range, r_state != S_SCAN || CNT_W'(r_idx) < r_count)
    `KNT_ASSERT_NEXT(a_done_to_idle, o_done, r_state == S_IDLE)
    `KNT_ASSERT_NEXT(a_count_step, r_state == S_SCAN || r_state == S_MISS,
                     r_count == $past(r_count) || r_count == $past(r_count) + CNT_W'(1)
                     || r_count == $past(r_count) - CNT_W'(1))

endmodule

FILE: rtl/keyed_neighbor_table.sv
// top level of the keyed neighbor table: stream ports and result register
`timescale 1ns / 1ps

// Keyed neighbor table: a dense table of up to 32 peers searched by 64-bit key.
// One request is taken at a time. A read passes through the read state and the
// done state before its result enters the output register. Add, seen, drop and
// find compare one live slot per cycle, with a further step when the key is
// missing or when a drop moves the last entry. An invalid action or an
// out-of-range read goes to the done state at once. The scan rate is set by the
// single 64-bit key compare fed from the one read port of the entry memory, which
// scans the live slots in order from slot 0. The next request is accepted on the
// cycle after the result enters the output register; while a held result is not
// taken, the finished request waits and no new request is accepted.
// Reset clears the live count and sets the next peer id to 1; the entry
// memory is not cleared and needs no clearing pass, since only live slots
// are ever read.
module keyed_neighbor_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // key, host_word, caps, index, zero pad
    input  logic [167:0]  s_axis_tdata,
    // action
    input  logic [2:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // peer_id, slot, entry_key, entry_host, entry_caps, live_count, zero pad
    output logic [207:0]  m_axis_tdata,
    // status
    output logic [1:0]    m_axis_tuser
);

    import knt_pkg::*;

    t_item          w_item;
    t_result        w_res;
    logic           w_ready;
    logic           w_done;
    logic           w_start;
    logic           w_out_free;

    logic           r_out_valid;
    logic [207:0]   r_out_data;
    logic [1:0]     r_out_user;

    assign w_item.action    = s_axis_tuser;
    assign w_item.key       = s_axis_tdata[63:0];
    assign w_item.host_word = s_axis_tdata[127:64];
    assign w_item.caps      = s_axis_tdata[159:128];
    assign w_item.index     = s_axis_tdata[164:160];

    assign w_start    = s_axis_tvalid && w_ready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    knt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_item     (w_item),
        .i_out_free (w_out_free),
        .o_ready    (w_ready),
        .o_done     (w_done),
        .o_result   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_done) begin
            r_out_user <= w_res.status;
            r_out_data <= {5'b0, w_res.live_count, w_res.entry_caps, w_res.entry_host,
                           w_res.entry_key, w_res.slot, w_res.peer_id};
        end
    end

    assign s_axis_tready = w_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
